// ----- rtl/core/function_call_syntax_checker_unit_defines.svh -----
// Assertion macros for the call syntax checker.
`ifndef FUNCTION_CALL_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define FUNCTION_CALL_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define FCSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FCSC_ASSERT(lbl, prop, msg)
`define FCSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/fcsc_pkg.sv -----
// Package: codes, character constants and shared types of the call syntax checker.
package fcsc_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int OUT_BITS = 16;

    localparam logic [1:0] PH_NAME   = 2'd0;
    localparam logic [1:0] PH_PARAMS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [1:0] SC_NEXT       = 2'd0;
    localparam logic [1:0] SC_QUOTED     = 2'd1;
    localparam logic [1:0] SC_UNQUOTED   = 2'd2;
    localparam logic [1:0] SC_POSTQUOTED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_NAME  = 2'd1;
    localparam logic [1:0] ST_BAD_PARAM = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] scan_state;
        logic [7:0] previous_char;
    } ctl_t;

    typedef struct packed {
        logic       emit;
        logic [1:0] status;
    } verdict_t;

endpackage

// ----- rtl/core/fcsc_in_if.sv -----
// Input word channel: one character or an end mark.
interface fcsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_end;

    modport source (output valid, output char_code, output is_end, input ready);
    modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

// ----- rtl/core/fcsc_out_if.sv -----
// Output word channel: one verdict.
interface fcsc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] name_length;
    logic [15:0] close_position;
    logic [15:0] last_param_offset;
    logic [15:0] last_param_length;

    modport source (output valid, output status, output name_length, output close_position,
                    output last_param_offset, output last_param_length, input ready);
    modport sink   (input valid, input status, input name_length, input close_position,
                    input last_param_offset, input last_param_length, output ready);
endinterface

// ----- rtl/core/function_call_syntax_checker_unit.sv -----
// Top level: call syntax checker over a character word stream.
// Verdicts are registered: word -> input register -> step logic -> result register.
// One word per cycle while the output is not stalled; each register holds one word.
// The per-string state updates in one pass of the step logic, so nothing iterates.
// Reset (rst_n low, asynchronous): no words held, list_mode 0, string state cleared.
`include "function_call_syntax_checker_unit_defines.svh"
module function_call_syntax_checker_unit #(
    parameter int POSITION_BITS = fcsc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    fcsc_in_if.sink    in_ch,
    fcsc_out_if.source out_ch
);

    localparam int WIDE_BITS = (POSITION_BITS > fcsc_pkg::OUT_BITS)
                               ? POSITION_BITS : fcsc_pkg::OUT_BITS;

    logic                     list_mode_reg;
    logic                     s1_valid_reg;
    logic [7:0]               s1_char_reg;
    logic                     s1_end_reg;
    fcsc_pkg::ctl_t           ctl_reg;
    fcsc_pkg::ctl_t           ctl_next;
    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;
    logic [POSITION_BITS-1:0] name_count_reg;
    logic [POSITION_BITS-1:0] name_count_next;
    logic [POSITION_BITS-1:0] param_start_reg;
    logic [POSITION_BITS-1:0] param_start_next;
    fcsc_pkg::verdict_t       verdict;
    logic [POSITION_BITS-1:0] close_pos;
    logic [POSITION_BITS-1:0] lp_offset;
    logic [POSITION_BITS-1:0] lp_length;
    logic [WIDE_BITS-1:0]     name_wide;
    logic [WIDE_BITS-1:0]     close_wide;
    logic [WIDE_BITS-1:0]     offset_wide;
    logic [WIDE_BITS-1:0]     length_wide;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [15:0]              name_length_reg;
    logic [15:0]              close_position_reg;
    logic [15:0]              last_param_offset_reg;
    logic [15:0]              last_param_length_reg;
    logic                     advance;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    fcsc_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .list_mode         (list_mode_reg),
        .char_code         (s1_char_reg),
        .is_end            (s1_end_reg),
        .ctl               (ctl_reg),
        .position          (position_reg),
        .name_count        (name_count_reg),
        .param_start       (param_start_reg),
        .ctl_next          (ctl_next),
        .position_next     (position_next),
        .name_count_next   (name_count_next),
        .param_start_next  (param_start_next),
        .verdict           (verdict),
        .close_position    (close_pos),
        .last_param_offset (lp_offset),
        .last_param_length (lp_length)
    );

    assign name_wide   = WIDE_BITS'(name_count_reg);
    assign close_wide  = WIDE_BITS'(close_pos);
    assign offset_wide = WIDE_BITS'(lp_offset);
    assign length_wide = WIDE_BITS'(lp_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_mode_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            ctl_reg         <= '0;
            position_reg    <= '0;
            name_count_reg  <= '0;
            param_start_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                list_mode_reg <= cfg_data;
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (advance)
            begin
                ctl_reg         <= ctl_next;
                position_reg    <= position_next;
                name_count_reg  <= name_count_next;
                param_start_reg <= param_start_next;
            end
            if (advance && verdict.emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_char_reg <= in_ch.char_code;
            s1_end_reg  <= in_ch.is_end;
        end
        if (advance && verdict.emit)
        begin
            status_reg            <= verdict.status;
            name_length_reg       <= name_wide[15:0];
            close_position_reg    <= close_wide[15:0];
            last_param_offset_reg <= offset_wide[15:0];
            last_param_length_reg <= length_wide[15:0];
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.status            = status_reg;
    assign out_ch.name_length       = name_length_reg;
    assign out_ch.close_position    = close_position_reg;
    assign out_ch.last_param_offset = last_param_offset_reg;
    assign out_ch.last_param_length = last_param_length_reg;

    // held word in the input register is not dropped under back pressure
    `FCSC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg, "input word lost")
    `FCSC_ASSERT(a_ok_len, !out_valid_reg || status_reg != fcsc_pkg::ST_OK || last_param_length_reg == 16'd0, "length on valid verdict")
    `FCSC_ASSERT(a_name_fields, !out_valid_reg || status_reg != fcsc_pkg::ST_BAD_NAME || (close_position_reg == 16'd0 && last_param_offset_reg == 16'd0), "fields on name failure")
    // a string that is done never produces a second verdict
    `FCSC_ASSERT(a_done_quiet, !(advance && ctl_reg.phase == fcsc_pkg::PH_DONE) || !verdict.emit, "verdict after done")

endmodule

// ----- rtl/core/fcsc_step.sv -----
// Per-character next-state and verdict logic.
module fcsc_step #(
    parameter int POSITION_BITS = fcsc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                     list_mode,
    input  logic [7:0]               char_code,
    input  logic                     is_end,
    input  fcsc_pkg::ctl_t           ctl,
    input  logic [POSITION_BITS-1:0] position,
    input  logic [POSITION_BITS-1:0] name_count,
    input  logic [POSITION_BITS-1:0] param_start,
    output fcsc_pkg::ctl_t           ctl_next,
    output logic [POSITION_BITS-1:0] position_next,
    output logic [POSITION_BITS-1:0] name_count_next,
    output logic [POSITION_BITS-1:0] param_start_next,
    output fcsc_pkg::verdict_t       verdict,
    output logic [POSITION_BITS-1:0] close_position,
    output logic [POSITION_BITS-1:0] last_param_offset,
    output logic [POSITION_BITS-1:0] last_param_length
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] name_inc;
    logic [POSITION_BITS-1:0] param_span;
    logic [1:0]               eff_phase;

    assign pos_inc    = (position == POS_MAX) ? POS_MAX : position + POS_ONE;
    assign name_inc   = (name_count == POS_MAX) ? POS_MAX : name_count + POS_ONE;
    assign param_span = (position >= param_start) ? position - param_start : '0;
    assign eff_phase  = (ctl.phase == fcsc_pkg::PH_NAME && list_mode)
                        ? fcsc_pkg::PH_PARAMS : ctl.phase;

    always_comb
    begin
        ctl_next          = ctl;
        position_next     = position;
        name_count_next   = name_count;
        param_start_next  = param_start;
        verdict.emit      = 1'b0;
        verdict.status    = fcsc_pkg::ST_OK;
        close_position    = '0;
        last_param_offset = '0;
        last_param_length = '0;

        if (ctl.phase == fcsc_pkg::PH_DONE)
        begin
            if (is_end)
            begin
                ctl_next         = '0;
                position_next    = '0;
                name_count_next  = '0;
                param_start_next = '0;
            end
        end
        else if (is_end || char_code == fcsc_pkg::CH_NUL)
        begin
            verdict.emit = 1'b1;
            if (ctl.phase == fcsc_pkg::PH_NAME && !list_mode)
            begin
                verdict.status = fcsc_pkg::ST_BAD_NAME;
            end
            else if (list_mode && ctl.scan_state != fcsc_pkg::SC_QUOTED)
            begin
                verdict.status    = fcsc_pkg::ST_OK;
                close_position    = position;
                last_param_offset = param_start;
            end
            else
            begin
                verdict.status    = fcsc_pkg::ST_BAD_PARAM;
                last_param_offset = param_start;
                last_param_length = param_span;
            end
            if (is_end)
            begin
                ctl_next         = '0;
                position_next    = '0;
                name_count_next  = '0;
                param_start_next = '0;
            end
            else
            begin
                ctl_next.phase = fcsc_pkg::PH_DONE;
            end
        end
        else
        begin
            ctl_next.phase = eff_phase;
            if (eff_phase == fcsc_pkg::PH_NAME)
            begin
                if (char_code inside {[8'h61:8'h7A]})
                begin
                    name_count_next = name_inc;
                end
                else if (char_code == fcsc_pkg::CH_LPAREN && name_count != '0)
                begin
                    ctl_next.phase      = fcsc_pkg::PH_PARAMS;
                    ctl_next.scan_state = fcsc_pkg::SC_NEXT;
                    param_start_next    = pos_inc;
                end
                else
                begin
                    verdict.emit   = 1'b1;
                    verdict.status = fcsc_pkg::ST_BAD_NAME;
                    ctl_next.phase = fcsc_pkg::PH_DONE;
                end
            end
            else if (!list_mode && char_code == fcsc_pkg::CH_RPAREN
                     && ctl.scan_state != fcsc_pkg::SC_QUOTED)
            begin
                verdict.emit      = 1'b1;
                verdict.status    = fcsc_pkg::ST_OK;
                close_position    = position;
                last_param_offset = param_start;
                ctl_next.phase    = fcsc_pkg::PH_DONE;
            end
            else
            begin
                case (ctl.scan_state)
                    fcsc_pkg::SC_NEXT:
                    begin
                        param_start_next = position;
                        if (char_code == fcsc_pkg::CH_QUOTE)
                            ctl_next.scan_state = fcsc_pkg::SC_QUOTED;
                        else if (char_code != fcsc_pkg::CH_SPACE
                                 && char_code != fcsc_pkg::CH_COMMA)
                            ctl_next.scan_state = fcsc_pkg::SC_UNQUOTED;
                    end
                    fcsc_pkg::SC_QUOTED:
                    begin
                        if (char_code == fcsc_pkg::CH_QUOTE
                            && ctl.previous_char != fcsc_pkg::CH_BSLASH)
                            ctl_next.scan_state = fcsc_pkg::SC_POSTQUOTED;
                    end
                    fcsc_pkg::SC_UNQUOTED:
                    begin
                        if (char_code == fcsc_pkg::CH_COMMA)
                            ctl_next.scan_state = fcsc_pkg::SC_NEXT;
                    end
                    default:
                    begin
                        if (char_code == fcsc_pkg::CH_COMMA)
                        begin
                            ctl_next.scan_state = fcsc_pkg::SC_NEXT;
                        end
                        else if (char_code != fcsc_pkg::CH_SPACE)
                        begin
                            verdict.emit      = 1'b1;
                            verdict.status    = fcsc_pkg::ST_BAD_PARAM;
                            last_param_offset = param_start;
                            last_param_length = param_span;
                            ctl_next.phase    = fcsc_pkg::PH_DONE;
                        end
                    end
                endcase
            end
            ctl_next.previous_char = char_code;
            position_next          = pos_inc;
        end
    end

endmodule
